>>> hdl/lru_age_tag_cache_core_assert.svh
// Assertion macros used by the port-level checker of the LRU tag cache.
`ifndef LRU_AGE_TAG_CACHE_CORE_ASSERT_SVH
`define LRU_AGE_TAG_CACHE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LATC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LATC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/latc_pkg.sv
// Shared types and constants of the LRU tag cache.
package latc_pkg;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam int SLOT_W     = 4;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_DONE
  } state_t;

  // Per-cycle commands from the sequencer to the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_valid;
  } mem_ctl_t;

endpackage

>>> hdl/latc_store.sv
// Entry store: key and age memory with registered read, plus valid flags.
module latc_store #(
  parameter int ENTRIES   = 16,
  parameter int AGE_WIDTH = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  latc_pkg::mem_ctl_t         mem_ctl,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  logic [KEY_WIDTH-1:0]       wr_key,
  input  logic [AGE_WIDTH-1:0]       wr_age,
  output logic [KEY_WIDTH-1:0]       rd_key,
  output logic [AGE_WIDTH-1:0]       rd_age,
  output logic                       rd_valid
);

  localparam int WORD_W = KEY_WIDTH + AGE_WIDTH;

  logic [WORD_W-1:0]  mem [ENTRIES];
  logic [WORD_W-1:0]  rd_word;
  logic [ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= {wr_key, wr_age};
    end
    if (mem_ctl.rd_en) begin
      rd_word  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // Entries are invalidated only by reset, so a slot's contents matter only after an
  // insert has written it; the memory itself needs no clearing.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_ctl.set_valid) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_key = rd_word[WORD_W-1:AGE_WIDTH];
  assign rd_age = rd_word[AGE_WIDTH-1:0];

endmodule

>>> hdl/latc_ctrl.sv
// Request sequencer: walks every entry once, matching, aging and picking a victim.
module latc_ctrl #(
  parameter int ENTRIES   = 16,
  parameter int AGE_WIDTH = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic                       req_cmd,
  input  logic [KEY_WIDTH-1:0]       req_key,
  output latc_pkg::mem_ctl_t         mem_ctl,
  output logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [$clog2(ENTRIES)-1:0] wr_addr,
  output logic [KEY_WIDTH-1:0]       wr_key,
  output logic [AGE_WIDTH-1:0]       wr_age,
  input  logic [KEY_WIDTH-1:0]       rd_key,
  input  logic [AGE_WIDTH-1:0]       rd_age,
  input  logic                       rd_valid,
  output logic                       done,
  input  logic                       done_ack,
  output logic                       res_hit,
  output logic [$clog2(ENTRIES)-1:0] res_pos
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [AGE_WIDTH-1:0] AGE_ONE = AGE_WIDTH'(1);

  latc_pkg::state_t state, state_next;

  logic                 cmd_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [IDX_W-1:0]     cnt;
  logic                 issue_done;
  logic                 proc_vld;
  logic [IDX_W-1:0]     proc_idx;
  logic                 found;
  logic [IDX_W-1:0]     pos;
  logic                 have_best;
  logic [AGE_WIDTH-1:0] best_age;
  logic [IDX_W-1:0]     victim;

  logic                 is_lookup;
  logic                 match_now;
  logic                 free_now;
  logic                 better_now;
  logic                 last_proc;
  logic                 accept;
  logic [AGE_WIDTH-1:0] age_inc;

  // The read of entry i+1 overlaps the write-back of entry i, so the two
  // ports never address the same entry in one cycle.
  always_comb begin
    is_lookup  = (cmd_q == latc_pkg::CMD_LOOKUP);
    match_now  = proc_vld && is_lookup && rd_valid && (rd_key == key_q) && !found;
    free_now   = proc_vld && !is_lookup && !rd_valid && !found;
    better_now = proc_vld && !is_lookup && rd_valid && !found &&
                 (!have_best || (rd_age > best_age));
    last_proc  = proc_vld && (proc_idx == LAST_IDX);
    age_inc    = (rd_age == '1) ? rd_age : rd_age + 1'b1;
    accept     = req_valid && req_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      latc_pkg::ST_IDLE: begin
        if (req_valid) state_next = latc_pkg::ST_SCAN;
      end
      latc_pkg::ST_SCAN: begin
        if (last_proc) begin
          if (!is_lookup && !found && !free_now) state_next = latc_pkg::ST_EVICT;
          else state_next = latc_pkg::ST_DONE;
        end
      end
      latc_pkg::ST_EVICT: state_next = latc_pkg::ST_DONE;
      latc_pkg::ST_DONE: begin
        if (done_ack) state_next = latc_pkg::ST_IDLE;
      end
      default: state_next = latc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    done      = 1'b0;
    mem_ctl   = '0;
    rd_addr   = cnt;
    wr_addr   = proc_idx;
    wr_key    = rd_key;
    wr_age    = age_inc;
    unique case (state)
      latc_pkg::ST_IDLE: req_ready = 1'b1;
      latc_pkg::ST_SCAN: begin
        mem_ctl.rd_en     = !issue_done;
        mem_ctl.wr_en     = proc_vld && (rd_valid || free_now);
        mem_ctl.set_valid = free_now;
        if (free_now) wr_key = key_q;
        if (match_now || free_now) wr_age = AGE_ONE;
      end
      latc_pkg::ST_EVICT: begin
        // The victim was aged during the walk; overwrite it as a fresh entry.
        mem_ctl.wr_en = 1'b1;
        wr_addr       = victim;
        wr_key        = key_q;
        wr_age        = AGE_ONE;
      end
      latc_pkg::ST_DONE: done = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= latc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req_cmd;
      key_q <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      issue_done <= 1'b0;
      proc_vld   <= 1'b0;
      proc_idx   <= '0;
      found      <= 1'b0;
      pos        <= '0;
      have_best  <= 1'b0;
      best_age   <= '0;
      victim     <= '0;
    end else if (accept) begin
      cnt        <= '0;
      issue_done <= 1'b0;
      proc_vld   <= 1'b0;
      found      <= 1'b0;
      pos        <= '0;
      have_best  <= 1'b0;
    end else if (state == latc_pkg::ST_SCAN) begin
      proc_vld <= !issue_done;
      proc_idx <= cnt;
      if (!issue_done) begin
        if (cnt == LAST_IDX) issue_done <= 1'b1;
        else cnt <= cnt + 1'b1;
      end
      if (match_now || free_now) begin
        found <= 1'b1;
        pos   <= proc_idx;
      end
      if (better_now) begin
        have_best <= 1'b1;
        best_age  <= rd_age;
        victim    <= proc_idx;
      end
    end else if (state == latc_pkg::ST_EVICT) begin
      pos <= victim;
    end
  end

  assign res_hit = found && is_lookup;
  assign res_pos = pos;

endmodule

>>> hdl/lru_age_tag_cache_core.sv
// A fully associative tag directory of ENTRIES slots with age-counter LRU
// replacement. Each request is a lookup (s_tuser low) or an insert (s_tuser
// high) of the key on s_tdata. The sequencer walks every entry once through
// the single read port of the entry memory, one entry per cycle, comparing
// keys on a lookup, aging valid entries and tracking the oldest on an insert;
// an insert that finds no free slot then passes through an evict state that
// writes the victim. No new request is taken until the last result has moved
// into the output register; it waits there, so the next request is accepted
// meanwhile. The entry memory is never cleared; valid flags are cleared by
// reset.
module lru_age_tag_cache_core #(
  parameter int ENTRIES   = 16,
  parameter int AGE_WIDTH = 16,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((KEY_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // key
  input  logic                                s_tuser,  // cmd
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [latc_pkg::OUT_DATA_W-1:0]      m_tdata,  // slot, zero padding
  output logic                                m_tuser   // hit
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int SLOT_W = latc_pkg::SLOT_W;

  latc_pkg::mem_ctl_t   mem_ctl;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [KEY_WIDTH-1:0] wr_key;
  logic [AGE_WIDTH-1:0] wr_age;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [AGE_WIDTH-1:0] rd_age;
  logic                 rd_valid;
  logic                 done;
  logic                 done_ack;
  logic                 res_hit;
  logic [IDX_W-1:0]     res_pos;

  logic [IDX_W+SLOT_W-1:0] pos_ext;
  logic [SLOT_W-1:0]       slot_q;
  logic                    hit_q;

  latc_ctrl #(
    .ENTRIES  (ENTRIES),
    .AGE_WIDTH(AGE_WIDTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_tvalid),
    .req_ready(s_tready),
    .req_cmd  (s_tuser),
    .req_key  (s_tdata[KEY_WIDTH-1:0]),
    .mem_ctl  (mem_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_age   (wr_age),
    .rd_key   (rd_key),
    .rd_age   (rd_age),
    .rd_valid (rd_valid),
    .done     (done),
    .done_ack (done_ack),
    .res_hit  (res_hit),
    .res_pos  (res_pos)
  );

  latc_store #(
    .ENTRIES  (ENTRIES),
    .AGE_WIDTH(AGE_WIDTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .mem_ctl (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_age  (wr_age),
    .rd_key  (rd_key),
    .rd_age  (rd_age),
    .rd_valid(rd_valid)
  );

  // The result moves into the output register once that register is empty or is being read out.
  assign done_ack = done && (!m_tvalid || m_tready);
  assign pos_ext  = {{SLOT_W{1'b0}}, res_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done_ack) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ack) begin
      hit_q  <= res_hit;
      slot_q <= pos_ext[SLOT_W-1:0];
    end
  end

  assign m_tdata = {{(latc_pkg::OUT_DATA_W - SLOT_W){1'b0}}, slot_q};
  assign m_tuser = hit_q;

endmodule

>>> hdl/latc_checker.sv
// Port-level checker for the LRU tag cache, bound to the top level.
`include "lru_age_tag_cache_core_assert.svh"

module latc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [latc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser
);

  `LATC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `LATC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
  `LATC_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while a walk is starting")
  `LATC_ASSERT_NOW(a_no_instant_result, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result without a full walk")

endmodule

bind lru_age_tag_cache_core latc_checker u_latc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
